>>> src/mrm_pkg.sv
package mrm_pkg;

	// Width of the window length register and its value after reset.
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] CFG_RESET = 6'd5;

	// Control that the sequencer sends down the row of cells.
	typedef struct packed {
		logic shift;   // take a new sample, restart the ranking pass
		logic rotate;  // one step of the ranking pass
	} mrm_ctl_t;

endpackage

>>> src/mrm_cell.sv
module mrm_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_W = 5,
	parameter int LEN_W = 6
) (
	input  logic                          clk,
	input  mrm_pkg::mrm_ctl_t             ctl,
	input  logic [AGE_W-1:0]              own_age,
	input  logic [LEN_W-1:0]              len,
	input  logic signed [SAMPLE_BITS-1:0] shift_in,
	input  logic signed [SAMPLE_BITS-1:0] trav_in,
	input  logic [AGE_W-1:0]              trav_age_in,
	output logic signed [SAMPLE_BITS-1:0] hist_q,
	output logic signed [SAMPLE_BITS-1:0] trav_q,
	output logic [AGE_W-1:0]              trav_age_q,
	output logic [LEN_W-1:0]              rank_q
);
	import mrm_pkg::*;

	logic less;
	logic in_win;

	// Stable ranking: an equal value ranks below when it is newer.
	assign less   = (trav_q < hist_q) || ((trav_q == hist_q) && (trav_age_q < own_age));
	assign in_win = LEN_W'(trav_age_q) < len;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hist_q     <= shift_in;
			trav_q     <= shift_in;
			trav_age_q <= own_age;
			rank_q     <= '0;
		end else if (ctl.rotate) begin
			trav_q     <= trav_in;
			trav_age_q <= trav_age_in;
			if (less && in_win) begin
				rank_q <= rank_q + LEN_W'(1);
			end
		end
	end

endmodule

>>> src/mrm_chain.sv
module mrm_chain #(
	parameter int MAX_WINDOW = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  mrm_pkg::mrm_ctl_t                       ctl,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]         len,
	input  logic signed [SAMPLE_BITS-1:0]           sample_in,
	output logic signed [SAMPLE_BITS-1:0]           med_lo,
	output logic signed [SAMPLE_BITS-1:0]           med_hi
);
	import mrm_pkg::*;

	localparam int AGE_W = $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	logic signed [SAMPLE_BITS-1:0] hist [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] trav [MAX_WINDOW];
	logic [AGE_W-1:0]              trav_age [MAX_WINDOW];
	logic [LEN_W-1:0]              rank [MAX_WINDOW];
	logic [LEN_W-1:0]              k_lo;
	logic [LEN_W-1:0]              k_hi;

	// Cell i holds the sample of age i; the travelling copies form a ring.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		localparam int PREV = (i + MAX_WINDOW - 1) % MAX_WINDOW;

		logic signed [SAMPLE_BITS-1:0] shift_src;

		if (i == 0) begin : g_head
			assign shift_src = sample_in;
		end else begin : g_body
			assign shift_src = hist[i-1];
		end

		mrm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.AGE_W(AGE_W),
			.LEN_W(LEN_W)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.own_age(AGE_W'(i)),
			.len(len),
			.shift_in(shift_src),
			.trav_in(trav[PREV]),
			.trav_age_in(trav_age[PREV]),
			.hist_q(hist[i]),
			.trav_q(trav[i]),
			.trav_age_q(trav_age[i]),
			.rank_q(rank[i])
		);
	end

	assign k_lo = LEN_W'(len - LEN_W'(1)) >> 1;
	assign k_hi = len >> 1;

	// Ranks inside the window are distinct, so each pick matches one cell.
	always_comb begin
		med_lo = '0;
		med_hi = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (LEN_W'(i) < len) begin
				if (rank[i] == k_lo) begin
					med_lo = med_lo | hist[i];
				end
				if (rank[i] == k_hi) begin
					med_hi = med_hi | hist[i];
				end
			end
		end
	end

endmodule

>>> src/masked_running_median_top.sv
// Channel | Direction | Signals                          | Contents
// s_axis  | in        | tvalid tready tdata tuser        | one sample request
// m_axis  | out       | tvalid tready tdata tuser        | one median result
// cfg     | in        | valid ready data                 | window length register
//
// From acceptance until its result is loaded, each sample is shifted into
// the cells, the sample copies travel once around the ring of cells for the
// ranking pass, the middle ranks are picked into registers, and the mean is
// formed and loaded once the output register is free.
// A new sample is accepted once the previous result is loaded into the
// output register, even while that result still waits there.
// A stalled output register holds the sequencer in its last step.
// Reset clears the counters, the sequencer and the output valid bit, and
// loads the window length with 5; the sample cells need no reset.
module masked_running_median_top #(
	parameter int MAX_WINDOW = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Sample requests.
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // sample
	input  logic                                    s_axis_tuser,  // sample_masked
	// Results.
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((SAMPLE_BITS+8)/8)*8-1:0]        m_axis_tdata,  // median_whole, median_half
	output logic                                    m_axis_tuser,  // out_masked
	// Window length writes.
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mrm_pkg::CFG_W-1:0]               cfg_data
);
	import mrm_pkg::*;

	localparam int AGE_W = $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RANK = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [CFG_W-1:0]              cfg_q;
	logic [LEN_W-1:0]              len_eff;
	logic [LEN_W-1:0]              len_q;
	logic [LEN_W-1:0]              seen_q;
	logic [LEN_W-1:0]              run_q;
	logic [LEN_W-1:0]              seen_nx;
	logic [LEN_W-1:0]              run_nx;
	logic                          mask_nx;
	logic                          mask_q;
	logic                          full_q;
	logic [AGE_W-1:0]              step_q;
	logic                          in_acc;
	logic                          out_free;
	logic                          out_load;
	mrm_ctl_t                      ctl;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic signed [SAMPLE_BITS-1:0] med_lo;
	logic signed [SAMPLE_BITS-1:0] med_hi;
	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [SAMPLE_BITS:0]   sum;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_whole_q;
	logic                          out_half_q;
	logic                          out_mask_q;

	assign cfg_ready = 1'b1;
	assign sample    = s_axis_tdata[SAMPLE_BITS-1:0];

	// A zero length means one sample; lengths past the cell count saturate.
	always_comb begin
		if (cfg_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(cfg_q) > MAX_WINDOW) begin
			len_eff = LEN_W'(MAX_WINDOW);
		end else begin
			len_eff = LEN_W'(cfg_q);
		end
	end

	// The run of unmasked samples counts up to the window length and holds.
	always_comb begin
		if (s_axis_tuser) begin
			run_nx = '0;
		end else if (run_q < len_eff) begin
			run_nx = run_q + LEN_W'(1);
		end else begin
			run_nx = run_q;
		end
		mask_nx = s_axis_tuser || (run_nx < len_eff);
		seen_nx = (seen_q < LEN_W'(MAX_WINDOW)) ? seen_q + LEN_W'(1) : seen_q;
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && out_free;

	assign ctl.shift  = in_acc;
	assign ctl.rotate = state_q == ST_RANK;

	mrm_chain #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chain (
		.clk(clk),
		.ctl(ctl),
		.len(len_q),
		.sample_in(sample),
		.med_lo(med_lo),
		.med_hi(med_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// Sequencer: shift in, one ring rotation, pick the middle, form the mean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			seen_q  <= '0;
			run_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						seen_q  <= seen_nx;
						run_q   <= run_nx;
						step_q  <= '0;
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					step_q <= step_q + AGE_W'(1);
					if (step_q == AGE_W'(MAX_WINDOW - 1)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			len_q  <= len_eff;
			mask_q <= mask_nx;
			full_q <= seen_nx >= len_eff;
		end
		if (state_q == ST_SEL) begin
			lo_q <= med_lo;
			hi_q <= med_hi;
		end
	end

	// The sum of the two middle values; its low bit is the half.
	assign sum = {lo_q[SAMPLE_BITS-1], lo_q} + {hi_q[SAMPLE_BITS-1], hi_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_whole_q <= full_q ? sum[SAMPLE_BITS:1] : '0;
			out_half_q  <= full_q ? sum[0] : 1'b0;
			out_mask_q  <= mask_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_half_q, out_whole_q});
	assign m_axis_tuser  = out_mask_q;

endmodule

>>> src/mrm_checker.sv
module mrm_checker #(
	parameter int MAX_WINDOW = 32,
	parameter int SAMPLE_BITS = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [((SAMPLE_BITS+8)/8)*8-1:0]   m_axis_tdata,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [mrm_pkg::CFG_W-1:0]          cfg_data
);
	import mrm_pkg::*;

	logic             in_acc;
	logic             out_acc;
	logic [1:0]       pend_q;
	logic [CFG_W-1:0] cfg_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cfg_q  <= CFG_RESET;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
		end
	end

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every result answers an earlier request.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result without a request");

	// At most one request in work and one result waiting.
	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests outstanding");

	// An odd window never yields a half.
	a_odd_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && cfg_q[0] && (int'(cfg_q) <= MAX_WINDOW) |->
			!m_axis_tdata[SAMPLE_BITS])
		else $error("half bit set for an odd window");

endmodule

bind masked_running_median_top mrm_checker #(
	.MAX_WINDOW(MAX_WINDOW),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_mrm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data(cfg_data)
);
